// ===== rtl/piq_pkg.sv =====
// shared types and constants for the positional insert queue
package piq_pkg;

   localparam int DEPTH           = 16;
   localparam int LETTER_W        = 8;
   localparam int POS_W           = 5;
   localparam int COUNT_W         = 5;
   localparam int CAP_W           = 5;
   localparam int TDATA_W         = 16;
   localparam int CNT_W           = $clog2(DEPTH + 1);
   localparam int IDX_W           = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W           = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int CMD_QUEUE_DEPTH = 4;
   localparam int QPTR_W          = $clog2(CMD_QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(CMD_QUEUE_DEPTH + 1);

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_DELETE = 1'b1;

   typedef struct packed {
      logic                is_delete;
      logic [LETTER_W-1:0] letter;
      logic [POS_W-1:0]    position;
   } cmd_type;

endpackage

// ===== rtl/piq_front.sv =====
// front end: takes request transactions, decodes them into queue commands
module piq_front
   import piq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,
   input  logic               req_tuser,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output cmd_type            cmd
);

   logic    hold_valid_ff, hold_valid_in;
   cmd_type hold_cmd_ff, hold_cmd_in;
   logic    take;

   assign req_tready = !hold_valid_ff || cmd_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      hold_cmd_in = hold_cmd_ff;
      if (take) begin
         hold_cmd_in.is_delete = (req_tuser == KIND_DELETE);
         hold_cmd_in.letter    = req_tdata[LETTER_W-1:0];
         // position zero lands at the front, same as position one
         if (req_tdata[LETTER_W +: POS_W] == '0) begin
            hold_cmd_in.position = POS_W'(1);
         end else begin
            hold_cmd_in.position = req_tdata[LETTER_W +: POS_W];
         end
      end
      if (take) begin
         hold_valid_in = 1'b1;
      end else if (cmd_ready) begin
         hold_valid_in = 1'b0;
      end else begin
         hold_valid_in = hold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_cmd_ff <= hold_cmd_in;
   end

   assign cmd_valid = hold_valid_ff;
   assign cmd       = hold_cmd_ff;

endmodule

// ===== rtl/piq_cmd_fifo.sv =====
// short command queue between the front end and the execution back end
module piq_cmd_fifo
   import piq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_cmd
);

   cmd_type            slots_ff [CMD_QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push, pop;

   assign in_ready  = (count_ff != QCNT_W'(CMD_QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = slots_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slots_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

// ===== rtl/piq_back.sv =====
// back end: holds the entries, applies inserts and deletes, streams the queue out
module piq_back
   import piq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [CAP_W-1:0]   csr_wr_data,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  cmd_type            cmd,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,
   output logic               rsp_tlast,
   output logic               rsp_tuser
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_STREAM = 1'b1;

   logic                state_ff, state_in;
   logic [LETTER_W-1:0] entries_ff [DEPTH];
   logic [LETTER_W-1:0] entries_in [DEPTH];
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CAP_W-1:0]    cap_ff;

   logic                out_valid_ff, out_valid_in;
   logic [LETTER_W-1:0] out_value_ff, out_value_in;
   logic                out_last_ff, out_last_in;
   logic                out_rej_ff, out_rej_in;
   logic [COUNT_W-1:0]  out_count_ff, out_count_in;

   logic                out_free, pop, full, at_last;
   logic [CMP_W-1:0]    fill_ext, slot;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign fill_ext  = CMP_W'(fill_ff);
   assign full      = (fill_ext >= CMP_W'(cap_ff)) || (fill_ext >= CMP_W'(DEPTH));
   assign cmd_ready = (state_ff == ST_IDLE) && (cmd.is_delete || out_free);
   assign pop       = cmd_valid && cmd_ready;
   // position is already at least one here
   assign slot      = (fill_ext < CMP_W'(cmd.position)) ? fill_ext
                                                        : CMP_W'(cmd.position) - 1'b1;
   assign at_last   = ((CNT_W'(idx_ff) + CNT_W'(1)) == fill_ff);

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      out_rej_in   = out_rej_ff;
      out_count_in = out_count_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      for (int i = 0; i < DEPTH; i++) begin
         entries_in[i] = entries_ff[i];
      end

      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               if (cmd.is_delete) begin
                  if (fill_ff != '0) begin
                     for (int i = 0; i < DEPTH - 1; i++) begin
                        entries_in[i] = entries_ff[i + 1];
                     end
                     fill_in = fill_ff - 1'b1;
                  end
               end else if (full) begin
                  out_valid_in = 1'b1;
                  out_value_in = '0;
                  out_last_in  = 1'b1;
                  out_rej_in   = 1'b1;
                  out_count_in = COUNT_W'(fill_ff);
               end else begin
                  // open a gap at the slot and drop the letter in
                  for (int i = 1; i < DEPTH; i++) begin
                     if (CMP_W'(i) > slot) begin
                        entries_in[i] = entries_ff[i - 1];
                     end
                  end
                  for (int i = 0; i < DEPTH; i++) begin
                     if (CMP_W'(i) == slot) begin
                        entries_in[i] = cmd.letter;
                     end
                  end
                  fill_in  = fill_ff + 1'b1;
                  idx_in   = '0;
                  state_in = ST_STREAM;
               end
            end
         end
         ST_STREAM: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_value_in = entries_ff[idx_ff];
               out_last_in  = at_last;
               out_rej_in   = 1'b0;
               out_count_in = COUNT_W'(fill_ff);
               if (at_last) begin
                  idx_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         idx_ff       <= '0;
         cap_ff       <= CAP_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
      for (int i = 0; i < DEPTH; i++) begin
         entries_ff[i] <= entries_in[i];
      end
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
      out_rej_ff   <= out_rej_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = TDATA_W'({out_count_ff, out_value_ff});
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_rej_ff;

endmodule

// ===== rtl/positional_insert_queue.sv =====
// top level of the positional insert queue
//
// Holds up to DEPTH byte letters in order. Request channel (req_): tuser says
// insert (0) or delete-front (1); tdata carries the letter and a 1-based
// insert position. Position zero means the front; a position past the count
// appends at the tail.
// An insert is refused when the count has reached csr capacity or DEPTH: one
// response with tuser set, data zero and the unchanged count. An accepted
// insert answers with every held entry front to back, one per cycle while
// rsp_tready is high, tlast on the final one, each carrying the new count.
// A delete gives no response. Requests pass an input register and a
// four-entry command queue, so the request side keeps taking transactions
// while responses drain. With nothing ahead, an insert passes the input
// register, command queue, entry update and response register; a refused one
// skips the entry update. An insert holds the execution unit (single response
// register) until its last entry is registered, others only while taken.
// Reset empties the queue and sets capacity to 16. csr_wr_en writes capacity;
// write it only while no work is in flight. When rsp_tready is low the
// response register holds and streaming pauses; the queue backs up upstream.
module positional_insert_queue
   import piq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [CAP_W-1:0]   csr_wr_data,   // capacity
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,     // [7:0] letter, [12:8] position, [15:13] zero
   input  logic               req_tuser,     // [0] kind
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,     // [7:0] entry_value, [12:8] entry_count, [15:13] zero
   output logic               rsp_tlast,
   output logic               rsp_tuser      // [0] rejected
);

   logic    front_valid, front_ready;
   cmd_type front_cmd;
   logic    back_valid, back_ready;
   cmd_type back_cmd;

   piq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready),
      .cmd        (front_cmd)
   );

   piq_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_cmd   (back_cmd)
   );

   piq_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_valid   (back_valid),
      .cmd_ready   (back_ready),
      .cmd         (back_cmd),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

// ===== rtl/piq_checker.sv =====
// port-level checks for the positional insert queue, bound to the top level
module piq_checker
   import piq_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               csr_wr_en,
   input logic [CAP_W-1:0]   csr_wr_data,
   input logic               req_tvalid,
   input logic               req_tready,
   input logic [TDATA_W-1:0] req_tdata,
   input logic               req_tuser,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [TDATA_W-1:0] rsp_tdata,
   input logic               rsp_tlast,
   input logic               rsp_tuser
);

   // a refused insert is a single transaction
   a_rej_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("rejected response without tlast");

   a_rej_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[LETTER_W-1:0] == '0)
      else $error("rejected response with nonzero entry value");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind positional_insert_queue piq_checker u_piq_checker (.*);
